[src/ppwm_pkg.sv]
// Package of constants, types and helpers for the periodic pattern window mismatch core.
package ppwm_pkg;

    localparam int WINDOW_MAX = 4096;
    localparam int PTR_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = PTR_W + 1;
    localparam int PHASES     = 3;

    localparam logic [CNT_W-1:0] BEST_INIT  = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] WIN_MAX_C  = CNT_W'(WINDOW_MAX);
    localparam logic [CNT_W-1:0] WIN_RESET  = CNT_W'(1);

    localparam logic [7:0] SYM_R = 8'h52;
    localparam logic [7:0] SYM_G = 8'h47;
    localparam logic [7:0] SYM_B = 8'h42;

    typedef enum logic [1:0] {
        CODE_R    = 2'd0,
        CODE_G    = 2'd1,
        CODE_B    = 2'd2,
        CODE_NONE = 2'd3
    } sym_code_t;

    typedef logic [PHASES-1:0] flags_t;
    typedef logic [CNT_W-1:0]  count_t;
    typedef logic [PTR_W-1:0]  ptr_t;

    function automatic sym_code_t symbol_code(input logic [7:0] sym);
        sym_code_t code;
        if (sym == SYM_R) begin
            code = CODE_R;
        end else if (sym == SYM_G) begin
            code = CODE_G;
        end else if (sym == SYM_B) begin
            code = CODE_B;
        end else begin
            code = CODE_NONE;
        end
        return code;
    endfunction

    // Bit j is set when phase j expects a different code at this position.
    function automatic flags_t mismatch_flags(input logic [7:0] sym, input logic [1:0] phase);
        sym_code_t  code;
        logic [2:0] sum;
        logic [1:0] exp_code;
        flags_t     flags;
        code  = symbol_code(sym);
        flags = '0;
        for (int j = 0; j < PHASES; j++) begin
            sum      = 3'(j) + {1'b0, phase};
            exp_code = (sum >= 3'd3) ? 2'(sum - 3'd3) : sum[1:0];
            flags[j] = (code == CODE_NONE) || (code != sym_code_t'(exp_code));
        end
        return flags;
    endfunction

    // Window length as used: zero acts as one, oversize is clipped.
    function automatic count_t effective_window(input count_t len);
        count_t w;
        if (len == '0) begin
            w = CNT_W'(1);
        end else if (len > WIN_MAX_C) begin
            w = WIN_MAX_C;
        end else begin
            w = len;
        end
        return w;
    endfunction

endpackage

[src/periodic_pattern_window_mismatch_min.sv]
// Top level of the periodic pattern window mismatch minimum core.
//
// A request is held in the input register, with its ring word read at acceptance;
// a last request then loads the output register, which drives m_valid.
// Throughput: one request per clock; a last request waits only while the previous
// result is still untaken. The ring has one write and one read port.
// Reset (aresetn low, synchronous) empties both registers, sets the window length
// to one and clears the sequence state; the ring itself is never cleared.
module periodic_pattern_window_mismatch_min_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_symbol,
    input  logic                      s_last,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [ppwm_pkg::CNT_W-1:0] m_min_changes,
    output logic                      m_valid_res,
    input  logic                      cfg_wr_en,
    input  logic [ppwm_pkg::CNT_W-1:0] cfg_wr_data
);

    localparam int NP = ppwm_pkg::PHASES;

    // Configuration register and the window length derived from it.
    ppwm_pkg::count_t win_len_reg;
    ppwm_pkg::count_t win_eff;

    // Input register: the request waiting for, or under, processing.
    logic             in_valid_reg;
    logic [7:0]       in_symbol_reg;
    logic             in_last_reg;

    // Sequence state.
    logic [1:0]       phase_reg, phase_next;
    ppwm_pkg::count_t fill_reg, fill_next;
    ppwm_pkg::ptr_t   wptr_reg, wptr_next;
    ppwm_pkg::count_t win_cnt_reg  [NP];
    ppwm_pkg::count_t win_cnt_next [NP];
    ppwm_pkg::count_t best_reg     [NP];
    ppwm_pkg::count_t best_next    [NP];

    // Mismatch flag ring with its registered read port.
    ppwm_pkg::flags_t ring_mem [ppwm_pkg::WINDOW_MAX];
    ppwm_pkg::flags_t ring_rd_reg;
    ppwm_pkg::ptr_t   rd_addr;
    ppwm_pkg::flags_t flags;
    ppwm_pkg::flags_t old_flags;

    // Output register.
    logic             out_valid_reg;
    ppwm_pkg::count_t out_min_reg;
    logic             out_vres_reg;

    logic             proc_go;
    logic             accept;
    logic             full_now;
    ppwm_pkg::count_t slot_inc;
    ppwm_pkg::ptr_t   slot_after;
    ppwm_pkg::count_t best_min;

    assign win_eff = ppwm_pkg::effective_window(win_len_reg);

    // A non-last request never produces a result, so it may be processed even
    // while the output register is still waiting to be taken.
    assign proc_go = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc_go;
    assign accept  = s_valid && s_ready;

    assign flags    = ppwm_pkg::mismatch_flags(in_symbol_reg, phase_reg);
    // The slot leaving the window is only meaningful once the window has filled.
    assign old_flags = (fill_reg >= win_eff) ? ring_rd_reg : '0;

    // Slot following the one used by the request in the input register.
    assign slot_inc   = {1'b0, wptr_reg} + ppwm_pkg::CNT_W'(1);
    assign slot_after = (slot_inc == win_eff) ? '0 : ppwm_pkg::PTR_W'(slot_inc);

    // The newly accepted request uses the slot after the current one, or slot
    // zero when the current request closes its sequence.
    always_comb begin
        if (in_valid_reg) begin
            rd_addr = in_last_reg ? '0 : slot_after;
        end else begin
            rd_addr = wptr_reg;
        end
    end

    // Window counts, fill level and running minima after this request.
    always_comb begin
        fill_next  = (fill_reg < win_eff) ? fill_reg + ppwm_pkg::CNT_W'(1) : fill_reg;
        full_now   = (fill_next >= win_eff);
        wptr_next  = slot_after;
        phase_next = (phase_reg >= 2'd2) ? 2'd0 : phase_reg + 2'd1;
        for (int j = 0; j < NP; j++) begin
            win_cnt_next[j] = win_cnt_reg[j]
                              - ppwm_pkg::CNT_W'(old_flags[j])
                              + ppwm_pkg::CNT_W'(flags[j]);
            if (full_now && (win_cnt_next[j] < best_reg[j])) begin
                best_next[j] = win_cnt_next[j];
            end else begin
                best_next[j] = best_reg[j];
            end
        end
        best_min = best_next[0];
        for (int j = 1; j < NP; j++) begin
            if (best_next[j] < best_min) begin
                best_min = best_next[j];
            end
        end
    end

    // Ring write and read. When the request being processed writes the very
    // slot now read (a window of one), the fresh flags are forwarded.
    always_ff @(posedge aclk) begin
        if (proc_go) begin
            ring_mem[wptr_reg] <= flags;
        end
        if (accept) begin
            if (proc_go && (wptr_reg == rd_addr)) begin
                ring_rd_reg <= flags;
            end else begin
                ring_rd_reg <= ring_mem[rd_addr];
            end
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_symbol_reg <= s_symbol;
            in_last_reg   <= s_last;
        end
    end

    // Control, sequence state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            win_len_reg   <= ppwm_pkg::WIN_RESET;
            phase_reg     <= '0;
            fill_reg      <= '0;
            wptr_reg      <= '0;
            for (int j = 0; j < NP; j++) begin
                win_cnt_reg[j] <= '0;
                best_reg[j]    <= ppwm_pkg::BEST_INIT;
            end
        end else begin
            if (accept) begin
                in_valid_reg <= 1'b1;
            end else if (proc_go) begin
                in_valid_reg <= 1'b0;
            end

            if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (proc_go && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end

            // A new window length starts a fresh sequence.
            if (cfg_wr_en) begin
                win_len_reg <= cfg_wr_data;
                phase_reg   <= '0;
                fill_reg    <= '0;
                wptr_reg    <= '0;
                for (int j = 0; j < NP; j++) begin
                    win_cnt_reg[j] <= '0;
                    best_reg[j]    <= ppwm_pkg::BEST_INIT;
                end
            end else if (proc_go) begin
                if (in_last_reg) begin
                    phase_reg <= '0;
                    fill_reg  <= '0;
                    wptr_reg  <= '0;
                    for (int j = 0; j < NP; j++) begin
                        win_cnt_reg[j] <= '0;
                        best_reg[j]    <= ppwm_pkg::BEST_INIT;
                    end
                end else begin
                    phase_reg <= phase_next;
                    fill_reg  <= fill_next;
                    wptr_reg  <= wptr_next;
                    for (int j = 0; j < NP; j++) begin
                        win_cnt_reg[j] <= win_cnt_next[j];
                        best_reg[j]    <= best_next[j];
                    end
                end
            end
        end
    end

    // Result payload: a sequence shorter than the window reports zero.
    always_ff @(posedge aclk) begin
        if (proc_go && in_last_reg) begin
            out_min_reg  <= full_now ? best_min : '0;
            out_vres_reg <= full_now;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_min_changes = out_min_reg;
    assign m_valid_res   = out_vres_reg;

    // The fill level never runs past the window.
    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= win_eff)
        else $error("fill level exceeds window length");

    // The ring pointer always stays inside the window.
    a_ptr_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, wptr_reg} < win_eff)
        else $error("ring pointer outside window");

    // Each phase count covers only symbols already held in the window.
    a_cnt_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (win_cnt_reg[0] <= fill_reg) && (win_cnt_reg[1] <= fill_reg)
        && (win_cnt_reg[2] <= fill_reg))
        else $error("window count exceeds fill level");

    // Closing a sequence leaves the sequence state empty.
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_go && in_last_reg) |=> (fill_reg == '0) && (wptr_reg == '0)
        && (phase_reg == '0))
        else $error("sequence state not cleared after last request");

    // An invalid result carries a zero count.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_valid_res) |-> (m_min_changes == '0))
        else $error("invalid result with non-zero count");

endmodule
